>>> rtl/core/ofg_pkg.sv
// Shared types, codes and reset constants of the overpressure fail-open guard.
package ofg_pkg;

  // Width of the trip and clear confirmation counters (4 to 16).
  localparam int CountBits = 8;
  // Width at which a counter is compared against its 8-bit confirm setting.
  localparam int CmpBits = (CountBits > 8) ? CountBits : 8;

  localparam int AddrBits = 5;
  localparam int DataBits = 32;

  typedef logic [CountBits-1:0] ofg_cnt_t;
  typedef logic [CmpBits-1:0]   ofg_cmp_t;

  localparam ofg_cnt_t CountMax = {CountBits{1'b1}};

  // Register reset values.
  localparam logic [15:0] TripThresholdRst  = 16'd150;
  localparam logic [15:0] ClearHystRst      = 16'd30;
  localparam logic        AutoClearRst      = 1'b1;
  localparam logic [7:0]  TripConfirmRst    = 8'd2;
  localparam logic [7:0]  ClearConfirmRst   = 8'd3;
  localparam logic [15:0] ArmLevelRst       = 16'd15;
  localparam logic [15:0] IdleLevelRst      = 16'd5;
  localparam logic [31:0] DisarmTimeRst     = 32'd60000;

  // Fault codes.
  localparam logic [1:0] FaultNone   = 2'd0;
  localparam logic [1:0] FaultSensor = 2'd3;

  // Reported guard state codes.
  localparam logic [1:0] GuardIdle    = 2'd0;
  localparam logic [1:0] GuardArmed   = 2'd1;
  localparam logic [1:0] GuardTripped = 2'd2;

  // Sampling cadence classes.
  localparam logic [1:0] CadenceBase   = 2'd0;
  localparam logic [1:0] CadenceSlow   = 2'd1;
  localparam logic [1:0] CadenceActive = 2'd2;

  typedef enum logic [1:0] {
    OpSample      = 2'd0,
    OpSensorFault = 2'd1,
    OpMotorFault  = 2'd2,
    OpManualClear = 2'd3
  } ofg_op_e;

  typedef enum logic [2:0] {
    RegTripThreshold = 3'd0,
    RegClearHyst     = 3'd1,
    RegAutoClear     = 3'd2,
    RegTripConfirm   = 3'd3,
    RegClearConfirm  = 3'd4,
    RegArmLevel      = 3'd5,
    RegIdleLevel     = 3'd6,
    RegDisarmTime    = 3'd7
  } ofg_reg_e;

  typedef enum logic [2:0] {
    ModeIdle    = 3'b001,
    ModeArmed   = 3'b010,
    ModeTripped = 3'b100
  } ofg_mode_e;

  typedef struct packed {
    logic [15:0] trip_threshold;
    logic [15:0] clear_hysteresis;
    logic        auto_clear;
    logic [7:0]  trip_confirm;
    logic [7:0]  clear_confirm;
    logic [15:0] arm_level;
    logic [15:0] idle_level;
    logic [31:0] disarm_time_ms;
  } ofg_cfg_t;

  typedef struct packed {
    ofg_op_e     opcode;
    logic [15:0] pressure;
    logic [31:0] time_ms;
    logic [1:0]  motor_fault;
  } ofg_item_t;

  typedef struct packed {
    ofg_mode_e   mode;
    logic        tripped;
    logic        latched;
    ofg_cnt_t    over_count;
    ofg_cnt_t    under_count;
    logic        low_seen;
    logic [31:0] low_start_ms;
    logic [15:0] last_trip_level;
    logic [1:0]  fault;
    logic        armed_once;
  } ofg_state_t;

  typedef struct packed {
    logic        open_req;
    logic        resume_req;
    logic        trip_toggled;
    logic        fault_toggled;
    logic        is_tripped;
    logic [1:0]  guard_state;
    logic [1:0]  fault_now;
    logic [1:0]  cadence_class;
    logic [15:0] trip_pressure;
  } ofg_result_t;

endpackage

>>> rtl/core/overpressure_fail_open_guard.sv
// A beat is held in the input register and its result in the output register.
// Throughput: one beat per cycle while out_ready_i is high; the input register, the step
// logic and the output register form a two-stage pipe, and guard state updates as a beat
// leaves the input stage. Reset (rst_ni low, asynchronous) empties both stages, returns the
// guard to idle with cleared counters and fault code, and loads the register defaults.
module overpressure_fail_open_guard (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ofg_pkg::AddrBits-1:0] paddr,
  input  logic [ofg_pkg::DataBits-1:0] pwdata,
  output logic [ofg_pkg::DataBits-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   opcode_i,
  input  logic [15:0]                  pressure_i,
  input  logic [31:0]                  time_ms_i,
  input  logic [1:0]                   motor_fault_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         open_req_o,
  output logic                         resume_req_o,
  output logic                         trip_toggled_o,
  output logic                         fault_toggled_o,
  output logic                         is_tripped_o,
  output logic [1:0]                   guard_state_o,
  output logic [1:0]                   fault_now_o,
  output logic [1:0]                   cadence_class_o,
  output logic [15:0]                  trip_pressure_o
);

  ofg_pkg::ofg_cfg_t    cfg;
  ofg_pkg::ofg_item_t   item_q;
  ofg_pkg::ofg_state_t  state_q, state_d;
  ofg_pkg::ofg_result_t res_q, res_d;
  logic                 in_valid_q, out_valid_q;
  logic                 in_take, advance;

  ofg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ofg_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // A beat moves on when the output register is empty or being drained.
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;
  assign in_take    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode            <= ofg_pkg::ModeIdle;
      state_q.tripped         <= 1'b0;
      state_q.latched         <= 1'b0;
      state_q.over_count      <= '0;
      state_q.under_count     <= '0;
      state_q.low_seen        <= 1'b0;
      state_q.low_start_ms    <= '0;
      state_q.last_trip_level <= '0;
      state_q.fault           <= ofg_pkg::FaultNone;
      state_q.armed_once      <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.opcode      <= ofg_pkg::ofg_op_e'(opcode_i);
      item_q.pressure    <= pressure_i;
      item_q.time_ms     <= time_ms_i;
      item_q.motor_fault <= motor_fault_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign open_req_o      = res_q.open_req;
  assign resume_req_o    = res_q.resume_req;
  assign trip_toggled_o  = res_q.trip_toggled;
  assign fault_toggled_o = res_q.fault_toggled;
  assign is_tripped_o    = res_q.is_tripped;
  assign guard_state_o   = res_q.guard_state;
  assign fault_now_o     = res_q.fault_now;
  assign cadence_class_o = res_q.cadence_class;
  assign trip_pressure_o = res_q.trip_pressure;

  // The tripped flag and the tripped mode always move together.
  a_trip_flag_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.tripped == (state_q.mode == ofg_pkg::ModeTripped))
    else $error("tripped flag and mode disagree");

  // A resume request always comes with a tripped-to-clear transition.
  a_resume_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && resume_req_o |-> !is_tripped_o && trip_toggled_o)
    else $error("resume without leaving the tripped state");

  // An open request always leaves the guard tripped.
  a_open_trips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && open_req_o |->
      is_tripped_o && guard_state_o == ofg_pkg::GuardTripped)
    else $error("open request while not tripped");

  // With an empty output register, the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with an empty output register");

endmodule

>>> rtl/core/ofg_cfg_regs.sv
// APB-style configuration register file of the guard.
module ofg_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ofg_pkg::AddrBits-1:0] paddr,
  input  logic [ofg_pkg::DataBits-1:0] pwdata,
  output logic [ofg_pkg::DataBits-1:0] prdata,
  output logic                         pready,
  output ofg_pkg::ofg_cfg_t            cfg_o
);

  ofg_pkg::ofg_cfg_t cfg_q, cfg_d;
  ofg_pkg::ofg_reg_e reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = ofg_pkg::ofg_reg_e'(paddr[ofg_pkg::AddrBits-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        ofg_pkg::RegTripThreshold: cfg_d.trip_threshold   = pwdata[15:0];
        ofg_pkg::RegClearHyst:     cfg_d.clear_hysteresis = pwdata[15:0];
        ofg_pkg::RegAutoClear:     cfg_d.auto_clear       = pwdata[0];
        ofg_pkg::RegTripConfirm:   cfg_d.trip_confirm     = pwdata[7:0];
        ofg_pkg::RegClearConfirm:  cfg_d.clear_confirm    = pwdata[7:0];
        ofg_pkg::RegArmLevel:      cfg_d.arm_level        = pwdata[15:0];
        ofg_pkg::RegIdleLevel:     cfg_d.idle_level       = pwdata[15:0];
        ofg_pkg::RegDisarmTime:    cfg_d.disarm_time_ms   = pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ofg_pkg::RegTripThreshold: prdata = {16'd0, cfg_q.trip_threshold};
      ofg_pkg::RegClearHyst:     prdata = {16'd0, cfg_q.clear_hysteresis};
      ofg_pkg::RegAutoClear:     prdata = {31'd0, cfg_q.auto_clear};
      ofg_pkg::RegTripConfirm:   prdata = {24'd0, cfg_q.trip_confirm};
      ofg_pkg::RegClearConfirm:  prdata = {24'd0, cfg_q.clear_confirm};
      ofg_pkg::RegArmLevel:      prdata = {16'd0, cfg_q.arm_level};
      ofg_pkg::RegIdleLevel:     prdata = {16'd0, cfg_q.idle_level};
      ofg_pkg::RegDisarmTime:    prdata = cfg_q.disarm_time_ms;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trip_threshold   <= ofg_pkg::TripThresholdRst;
      cfg_q.clear_hysteresis <= ofg_pkg::ClearHystRst;
      cfg_q.auto_clear       <= ofg_pkg::AutoClearRst;
      cfg_q.trip_confirm     <= ofg_pkg::TripConfirmRst;
      cfg_q.clear_confirm    <= ofg_pkg::ClearConfirmRst;
      cfg_q.arm_level        <= ofg_pkg::ArmLevelRst;
      cfg_q.idle_level       <= ofg_pkg::IdleLevelRst;
      cfg_q.disarm_time_ms   <= ofg_pkg::DisarmTimeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/ofg_step.sv
// Next-state and result logic for one beat of the guard.
module ofg_step (
  input  ofg_pkg::ofg_cfg_t    cfg_i,
  input  ofg_pkg::ofg_state_t  state_i,
  input  ofg_pkg::ofg_item_t   item_i,
  output ofg_pkg::ofg_state_t  state_o,
  output ofg_pkg::ofg_result_t result_o
);

  ofg_pkg::ofg_state_t s;
  logic        opn, res, tchg, fchg, handle;
  logic [15:0] clear_lvl;
  logic [31:0] elapsed;
  logic [1:0]  gstate;
  logic [1:0]  cad;

  assign clear_lvl = (cfg_i.clear_hysteresis >= cfg_i.trip_threshold) ? 16'd0
                   : cfg_i.trip_threshold - cfg_i.clear_hysteresis;
  assign elapsed   = item_i.time_ms - state_i.low_start_ms;

  always_comb begin
    s      = state_i;
    opn    = 1'b0;
    res    = 1'b0;
    tchg   = 1'b0;
    fchg   = 1'b0;
    handle = 1'b1;
    case (item_i.opcode)
      ofg_pkg::OpSample: begin
        // A good sample clears a pending sensor fault.
        if (s.fault == ofg_pkg::FaultSensor) begin
          s.fault = ofg_pkg::FaultNone;
          fchg    = 1'b1;
        end
        if (s.mode == ofg_pkg::ModeTripped) begin
          if (!s.latched) begin
            if (item_i.pressure < clear_lvl) begin
              if (s.under_count != ofg_pkg::CountMax) begin
                s.under_count = s.under_count + 1'b1;
              end
              if (ofg_pkg::ofg_cmp_t'(s.under_count) >=
                  ofg_pkg::ofg_cmp_t'(cfg_i.clear_confirm)) begin
                s.under_count = '0;
                if (cfg_i.auto_clear) begin
                  s.tripped  = 1'b0;
                  tchg       = 1'b1;
                  res        = 1'b1;
                  s.low_seen = 1'b0;
                  s.mode     = (item_i.pressure >= cfg_i.arm_level) ?
                               ofg_pkg::ModeArmed : ofg_pkg::ModeIdle;
                end else begin
                  s.latched = 1'b1;
                end
              end
            end else begin
              s.under_count = '0;
            end
          end
        end else begin
          if (s.mode != ofg_pkg::ModeArmed) begin
            // The arming sample goes on to be handled as an armed sample.
            if (item_i.pressure >= cfg_i.arm_level) begin
              s.mode       = ofg_pkg::ModeArmed;
              s.armed_once = 1'b1;
              s.over_count = '0;
              s.low_seen   = 1'b0;
            end else begin
              s.mode = ofg_pkg::ModeIdle;
              handle = 1'b0;
            end
          end
          if (handle) begin
            if (item_i.pressure > cfg_i.trip_threshold) begin
              if (s.over_count != ofg_pkg::CountMax) begin
                s.over_count = s.over_count + 1'b1;
              end
              if (ofg_pkg::ofg_cmp_t'(s.over_count) >=
                  ofg_pkg::ofg_cmp_t'(cfg_i.trip_confirm)) begin
                s.mode            = ofg_pkg::ModeTripped;
                s.latched         = 1'b0;
                s.over_count      = '0;
                s.under_count     = '0;
                s.last_trip_level = item_i.pressure;
                if (!s.tripped) begin
                  s.tripped = 1'b1;
                  tchg      = 1'b1;
                end
                opn = 1'b1;
              end
            end else begin
              s.over_count = '0;
              if (item_i.pressure <= cfg_i.idle_level) begin
                if (!s.low_seen) begin
                  s.low_seen     = 1'b1;
                  s.low_start_ms = item_i.time_ms;
                end else if (elapsed >= cfg_i.disarm_time_ms) begin
                  s.mode       = ofg_pkg::ModeIdle;
                  s.over_count = '0;
                end
              end else begin
                s.low_seen = 1'b0;
              end
            end
          end
        end
      end
      ofg_pkg::OpSensorFault: begin
        if (s.fault != ofg_pkg::FaultSensor) begin
          s.fault = ofg_pkg::FaultSensor;
          fchg    = 1'b1;
        end
        if (!s.tripped) begin
          s.tripped     = 1'b1;
          tchg          = 1'b1;
          opn           = 1'b1;
          s.mode        = ofg_pkg::ModeTripped;
          s.latched     = 1'b0;
          s.over_count  = '0;
          s.under_count = '0;
        end
      end
      ofg_pkg::OpMotorFault: begin
        if (s.fault != item_i.motor_fault) begin
          s.fault = item_i.motor_fault;
          fchg    = 1'b1;
        end
      end
      ofg_pkg::OpManualClear: begin
        if (s.tripped) begin
          s.tripped     = 1'b0;
          s.latched     = 1'b0;
          s.under_count = '0;
          s.over_count  = '0;
          s.mode        = ofg_pkg::ModeIdle;
          tchg          = 1'b1;
          res           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (s.mode)
      ofg_pkg::ModeArmed: begin
        gstate = ofg_pkg::GuardArmed;
        cad    = ofg_pkg::CadenceActive;
      end
      ofg_pkg::ModeTripped: begin
        gstate = ofg_pkg::GuardTripped;
        cad    = ofg_pkg::CadenceActive;
      end
      default: begin
        gstate = ofg_pkg::GuardIdle;
        cad    = s.armed_once ? ofg_pkg::CadenceSlow : ofg_pkg::CadenceBase;
      end
    endcase
  end

  assign state_o                = s;
  assign result_o.open_req      = opn;
  assign result_o.resume_req    = res;
  assign result_o.trip_toggled  = tchg;
  assign result_o.fault_toggled = fchg;
  assign result_o.is_tripped    = s.tripped;
  assign result_o.guard_state   = gstate;
  assign result_o.fault_now     = s.fault;
  assign result_o.cadence_class = cad;
  assign result_o.trip_pressure = s.last_trip_level;

endmodule
